/* design/esc_pkg.sv */
package esc_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;

    // Each divisor is a power of two, taken off by a shift, times an odd factor
    // that is reached by a multiply with a rounded-up reciprocal and a shift.
    // The reciprocals are exact over the whole range of each dividend.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam logic [11:0] BASE_YEAR        = 12'd1970;
    localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;
    localparam logic [8:0]  DAYS_COMMON_YEAR = 9'd365;

    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    typedef struct packed {
        logic        ge;
        logic [31:0] diff;
    } sub_res_t;

    // Years reachable here run from 1970 to 2106, where the only
    // century that breaks the four-year rule is 2100 (2000 is a leap year).
    function automatic logic is_leap(input logic [11:0] year);
        is_leap = (year[1:0] == 2'b00) && (year != NON_LEAP_CENTURY);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MON_FEB)
            len = leap ? 5'd29 : 5'd28;
        else if (month inside {MON_APR, MON_JUN, MON_SEP, MON_NOV})
            len = 5'd30;
        else
            len = 5'd31;
        month_len = len;
    endfunction

    // 86400 is 128 times 675.
    function automatic logic [15:0] day_quot(input logic [31:0] secs);
        logic [50:0] prod;
        prod     = {26'd0, secs[31:7]} * 51'(DAY_RECIP);
        day_quot = prod[50:35];
    endfunction

    // 3600 is 16 times 225; the seconds of the day fit in 17 bits.
    function automatic logic [4:0] hour_quot(input logic [16:0] sod);
        logic [26:0] prod;
        prod      = {14'd0, sod[16:4]} * 27'(HOUR_RECIP);
        hour_quot = prod[25:21];
    endfunction

    // 60 is 4 times 15; the seconds of the hour fit in 12 bits.
    function automatic logic [5:0] minute_quot(input logic [11:0] soh);
        logic [20:0] prod;
        prod        = {11'd0, soh[11:2]} * 21'(MIN_RECIP);
        minute_quot = prod[19:14];
    endfunction

endpackage

/* design/esc_sub_unit.sv */
module esc_sub_unit (
    input  logic [31:0]       a,
    input  logic [31:0]       b,
    output esc_pkg::sub_res_t res
);
    import esc_pkg::*;

    logic [WORD_W:0] wide;

    assign wide     = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~wide[WORD_W];
    assign res.diff = wide[WORD_W-1:0];

endmodule

/* design/epoch_seconds_to_calendar.sv */
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into a
// Gregorian date and time of day.
//
// Input: a transfer happens at the rising edge where start is high and busy
// is low; epoch_seconds is sampled at that edge. busy stays high for the whole
// conversion and no new item is taken meanwhile.
// Output: done is high for exactly one cycle with the cal_* ports valid. The
// receiver cannot stall; the cal_* ports hold their value until the next done.
// done is asserted in the cycle after the last step, while busy is already
// low, so the next start can be taken in the same cycle.
//
// Steps: each of the day, hour and minute splits runs a reciprocal multiply, a
// multiply back and a subtract; the year walk then takes off whole years while
// they fit, the month walk whole months, and done follows. A conversion is
// shortest at 1970-01-01 and longest in December 2105. The remainders and the year
// and month steps share one 32-bit compare-and-subtract unit; the year walk is longest.
//
// Reset clears the sequencer and the done strobe; an item in progress is lost.
module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [11:0] cal_year,
    output logic [3:0]  cal_month,
    output logic [4:0]  cal_day,
    output logic [4:0]  cal_hour,
    output logic [5:0]  cal_minute,
    output logic [5:0]  cal_second
);
    import esc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DAYS  = 3'd1;
    localparam logic [2:0] ST_HOUR  = 3'd2;
    localparam logic [2:0] ST_MIN   = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;

    localparam logic [1:0] STEP_QUOT = 2'd0;
    localparam logic [1:0] STEP_PROD = 2'd1;
    localparam logic [1:0] STEP_SUB  = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic        done_reg, done_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [15:0] quo_reg, quo_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] days_reg, days_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;

    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [4:0]  out_hour_reg;
    logic [5:0]  out_minute_reg;
    logic [5:0]  out_second_reg;
    logic        finish;

    logic [31:0] op_a, op_b;
    sub_res_t    sub;
    logic        leap;
    logic [15:0] quo_calc;
    logic [31:0] prod_calc;

    assign leap = is_leap(year_reg);

    // Quotient of the current split, and that quotient times its divisor.
    always_comb
    begin
        case (state_reg)
            ST_HOUR:
            begin
                quo_calc  = {11'd0, hour_quot(rem_reg[16:0])};
                prod_calc = {16'd0, quo_reg} * SECS_PER_HOUR;
            end
            ST_MIN:
            begin
                quo_calc  = {10'd0, minute_quot(rem_reg[11:0])};
                prod_calc = {16'd0, quo_reg} * SECS_PER_MIN;
            end
            default:
            begin
                quo_calc  = day_quot(rem_reg);
                prod_calc = {16'd0, quo_reg} * SECS_PER_DAY;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_YEAR:
            begin
                op_a = {16'd0, days_reg};
                op_b = {23'd0, DAYS_COMMON_YEAR + {8'd0, leap}};
            end
            ST_MONTH:
            begin
                op_a = {16'd0, days_reg};
                op_b = {27'd0, month_len(month_reg, leap)};
            end
            default:
            begin
                op_a = rem_reg;
                op_b = div_reg;
            end
        endcase
    end

    esc_sub_unit u_sub (
        .a   (op_a),
        .b   (op_b),
        .res (sub)
    );

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        days_next   = days_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        finish      = 1'b0;
        done_next   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DAYS;
                    rem_next   = epoch_seconds;
                    cnt_next   = STEP_QUOT;
                end
            end
            ST_DAYS, ST_HOUR, ST_MIN:
            begin
                case (cnt_reg)
                    STEP_QUOT:
                    begin
                        quo_next = quo_calc;
                        cnt_next = STEP_PROD;
                    end
                    STEP_PROD:
                    begin
                        div_next = prod_calc;
                        cnt_next = STEP_SUB;
                    end
                    default:
                    begin
                        // The product never exceeds the dividend, so the
                        // difference is the exact remainder.
                        rem_next = sub.diff;
                        cnt_next = STEP_QUOT;
                        if (state_reg == ST_DAYS)
                        begin
                            days_next  = quo_reg;
                            state_next = ST_HOUR;
                        end
                        else if (state_reg == ST_HOUR)
                        begin
                            hour_next  = quo_reg[4:0];
                            state_next = ST_MIN;
                        end
                        else
                        begin
                            minute_next = quo_reg[5:0];
                            year_next   = BASE_YEAR;
                            state_next  = ST_YEAR;
                        end
                    end
                endcase
            end
            ST_YEAR:
            begin
                if (sub.ge)
                begin
                    days_next = sub.diff[15:0];
                    year_next = year_reg + 12'd1;
                end
                else
                begin
                    month_next = MON_JAN;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                // December is never tested: whatever is left belongs to it.
                if (sub.ge && month_reg != MON_DEC)
                begin
                    days_next  = sub.diff[15:0];
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    finish     = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        days_reg   <= days_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        if (finish)
        begin
            out_year_reg   <= year_reg;
            out_month_reg  <= month_reg;
            out_day_reg    <= days_reg[4:0] + 5'd1;
            out_hour_reg   <= hour_reg;
            out_minute_reg <= minute_reg;
            out_second_reg <= rem_reg[5:0];
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cal_year   = out_year_reg;
    assign cal_month  = out_month_reg;
    assign cal_day    = out_day_reg;
    assign cal_hour   = out_hour_reg;
    assign cal_minute = out_minute_reg;
    assign cal_second = out_second_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while a conversion is still running");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not start a conversion");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR) |-> (year_reg <= 12'd2106))
        else $error("year walk ran past the input range");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MONTH) |-> (month_reg <= MON_DEC && days_reg <= 16'd365))
        else $error("month walk out of range");

    a_sod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR) |-> (rem_reg < SECS_PER_MIN))
        else $error("seconds remainder not reduced below one minute");
`endif

endmodule

/* test/epoch_seconds_to_calendar_tb.sv */
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;

    import esc_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned RANDOM_ITEMS = 400;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // Epoch, minute, hour and day edges, the ends of the range, leap days in 1972
    // and 2000, year ends, and the missing leap day of 2100.
    localparam int unsigned DIRECTED_COUNT = 20;
    localparam logic [31:0] DIRECTED_TIMES [DIRECTED_COUNT] = '{
        32'd0,          32'd59,         32'd60,         32'd3599,
        32'd3600,       32'd86399,      32'd86400,      32'd31535999,
        32'd31536000,   32'd68169600,   32'd94694399,   32'd951782400,
        32'd951868799,  32'd951868800,  32'd4107542399, 32'd4107542400,
        32'd4291747200, 32'h7FFFFFFF,   32'hFFFFFFFE,   32'hFFFFFFFF
    };

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    class calendar_scoreboard;
        calendar_t pending_dates[$];
        int unsigned errors = 0;

        function bit year_is_leap(int unsigned year);
            return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
        endfunction

        function calendar_t calendar_of(logic [31:0] secs);
            int unsigned days;
            int unsigned sod;
            int unsigned year;
            int unsigned month;
            int unsigned span;
            calendar_t   date;
            sod  = secs % SECS_PER_DAY;
            days = secs / SECS_PER_DAY;
            year = BASE_YEAR;
            span = DAYS_COMMON_YEAR + year_is_leap(year);
            while (days >= span)
            begin
                days -= span;
                year++;
                span = DAYS_COMMON_YEAR + year_is_leap(year);
            end
            // The leftover days always fit in the year, so December is the last stop.
            for (month = MON_JAN; month < MON_DEC; month++)
            begin
                span = MONTH_DAYS[month];
                if (month == MON_FEB && year_is_leap(year))
                    span++;
                if (days < span)
                    break;
                days -= span;
            end
            date.year   = year[11:0];
            date.month  = month[3:0];
            date.day    = 5'(days + 1);
            date.hour   = 5'(sod / SECS_PER_HOUR);
            date.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
            date.second = 6'(sod % SECS_PER_MIN);
            return date;
        endfunction

        function void note_epoch(logic [31:0] secs);
            pending_dates.push_back(calendar_of(secs));
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_calendar(calendar_t got);
            calendar_t want;
            if (pending_dates.size() == 0)
            begin
                $error("result strobe with no conversion outstanding");
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            compare_field("cal_year",   want.year,   got.year);
            compare_field("cal_month",  want.month,  got.month);
            compare_field("cal_day",    want.day,    got.day);
            compare_field("cal_hour",   want.hour,   got.hour);
            compare_field("cal_minute", want.minute, got.minute);
            compare_field("cal_second", want.second, got.second);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] epoch_seconds;
    logic        done;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;

    calendar_scoreboard sb = new();
    int unsigned idle_cycles = 0;

    epoch_seconds_to_calendar dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .epoch_seconds (epoch_seconds),
        .done          (done),
        .cal_year      (cal_year),
        .cal_month     (cal_month),
        .cal_day       (cal_day),
        .cal_hour      (cal_hour),
        .cal_minute    (cal_minute),
        .cal_second    (cal_second)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Transfers are observed on the values present just before each rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_calendar({cal_year, cal_month, cal_day,
                                   cal_hour, cal_minute, cal_second});
            if (start && !busy)
                sb.note_epoch(epoch_seconds);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Holds start high until the edge where busy is low, so the transfer
    // happens at the edge this task returns on.
    task automatic send_epoch(input logic [31:0] secs);
        start         <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        start         <= 1'b0;
        epoch_seconds <= $urandom;
        repeat (cycles)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned burst_left;
        int unsigned pick;
        int unsigned gap;
        logic [31:0] secs;

        rst_n         = 1'b0;
        start         = 1'b0;
        epoch_seconds = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_epoch(DIRECTED_TIMES[i]);
        pause_sender(3);

        burst_left = $urandom_range(1, 20);
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                secs = $urandom;
            else if (pick < 7)
                secs = $urandom_range(0, 49709) * SECS_PER_DAY
                       + ($urandom_range(0, 1) ? 32'd86399 : 32'd0);
            else if (pick < 8)
                secs = $urandom_range(0, 86400 * 1200);
            else
                secs = $urandom_range(946684800, 32'hFFFFFFFF);
            send_epoch(secs);

            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    gap = 0;
                else if (pick < 8)
                    gap = $urandom_range(1, 20);
                else
                    gap = $urandom_range(21, 220);
                if (gap != 0)
                    pause_sender(gap);
            end
        end
        pause_sender(1);

        while (sb.pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
design/esc_pkg.sv
design/esc_sub_unit.sv
design/epoch_seconds_to_calendar.sv
test/epoch_seconds_to_calendar_tb.sv
